// ----- src/isl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants of the iSLIP crossbar scheduler
// Bitmap width, default port count and the result item layout.
// ----------------------------------------------------------------------------
package isl_pkg;

    // Width of the request, grant and match bitmaps on the ports
    localparam int MAP_W     = 16;
    // Default crossbar size (ports per side)
    localparam int PORTS_DEF = 4;

    typedef logic [MAP_W-1:0] map_t;

    // One result item: match and grant bitmaps
    typedef struct packed {
        map_t match_map;
        map_t grant_map;
    } result_t;

endpackage

// ----- src/isl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_if: valid/ready channels of the iSLIP crossbar scheduler
// Request channel carries the VOQ occupancy bitmap, result channel the
// match and grant bitmaps.
// ----------------------------------------------------------------------------
interface isl_req_if;
    import isl_pkg::*;

    logic valid;
    logic ready;
    map_t voq_nonempty;

    modport source (output valid, output voq_nonempty, input ready);
    modport sink   (input valid, input voq_nonempty, output ready);
endinterface

interface isl_res_if;
    import isl_pkg::*;

    logic valid;
    logic ready;
    map_t match_map;
    map_t grant_map;

    modport source (output valid, output match_map, output grant_map, input ready);
    modport sink   (input valid, input match_map, input grant_map, output ready);
endinterface

// ----- src/isl_rr_arb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_rr_arb: round-robin arbiter lane
// Picks the first set request at or after the pointer, wrapping round.
// Used for both the grant lanes (per output) and accept lanes (per input).
// ----------------------------------------------------------------------------
module isl_rr_arb #(
    parameter  int N = 4,
    localparam int W = (N > 1) ? $clog2(N) : 1
) (
    input  logic [N-1:0] req,
    input  logic [W-1:0] ptr,
    output logic [N-1:0] gnt,
    output logic [W-1:0] idx,
    output logic         any
);
    import isl_pkg::*;

    logic [N-1:0] upper;
    logic [N-1:0] search;

    // Requests at or above the pointer take priority
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            upper[k] = req[k] && (k >= int'(ptr));
        end
        search = (|upper) ? upper : req;
    end

    // Lowest set bit of the chosen vector
    always_comb
    begin
        idx = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (search[k])
            begin
                idx = W'(k);
            end
        end
        any = |req;
        gnt = '0;
        if (any)
        begin
            gnt[idx] = 1'b1;
        end
    end

endmodule

// ----- src/isl_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_out_buf: output register with skid stage
// Holds a finished result while the receiver stalls and takes one more
// item in the skid register, so upstream ready never waits on downstream.
// ----------------------------------------------------------------------------
module isl_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  isl_pkg::result_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output isl_pkg::result_t  out_data
);
    import isl_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    in_take;
    logic    out_take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_take  = main_valid_reg && out_ready;

    // Refill main from skid first, then from the input
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_take || !main_valid_reg)
        begin
            main_valid_next = skid_valid_reg || in_take;
            main_next       = skid_valid_reg ? skid_reg : in_data;
            skid_valid_next = 1'b0;
        end
        else if (in_take)
        begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // Skid only ever fills behind an occupied main register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds an item while main register is empty");

    // A stalled result is never dropped
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && !out_ready) |=> main_valid_reg)
        else $error("stalled result lost");

    // An item arriving behind a stalled result lands in the skid
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && main_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("item accepted behind stalled result not kept");

endmodule

// ----- src/islip_crossbar_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// islip_crossbar_scheduler: single-iteration iSLIP matcher
// One matching decision per cell time for a PORTS x PORTS crossbar.
//
// Channels: requests carries voq_nonempty, bit i*PORTS+j set when input i
// holds cells for output j. results carries match_map and grant_map in the
// same bit layout. Both are valid/ready; an item moves when both are high.
// Bits beyond PORTS*PORTS are ignored on input and driven zero on output.
//
// Throughput: one item per cycle while the output buffer can take it. Grant
// arbiters, accept arbiters and the pointer update sit in the same cycle,
// since each decision feeds the pointers the next item starts from. Each
// result is registered in the output buffer before it appears on results.
// Stall: a two-entry output buffer (register plus skid) keeps requests.ready
// high while one result waits; it drops only once two results are queued.
// Reset: all grant and accept pointers return to zero, no result pending.
// ----------------------------------------------------------------------------
module islip_crossbar_scheduler #(
    parameter int PORTS = isl_pkg::PORTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    isl_req_if.sink     requests,
    isl_res_if.source   results
);
    import isl_pkg::*;

    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;

    // col_req[j][i]: input i requests output j
    logic [PORTS-1:0][PORTS-1:0] col_req;
    // col_gnt[j][i]: output j grants input i
    logic [PORTS-1:0][PORTS-1:0] col_gnt;
    // row_gnt[i][j]: same grants, seen per input
    logic [PORTS-1:0][PORTS-1:0] row_gnt;
    // row_acc[i][j]: input i accepts output j
    logic [PORTS-1:0][PORTS-1:0] row_acc;

    logic [PORTS-1:0][PW-1:0] gidx;
    logic [PORTS-1:0]         gany;
    logic [PORTS-1:0][PW-1:0] aidx;
    logic [PORTS-1:0]         aany;
    logic [PORTS-1:0]         col_accepted;

    logic [PORTS-1:0][PW-1:0] gptr_reg;
    logic [PORTS-1:0][PW-1:0] gptr_next;
    logic [PORTS-1:0][PW-1:0] aptr_reg;
    logic [PORTS-1:0][PW-1:0] aptr_next;

    map_t    req_flat;
    map_t    grant_flat;
    map_t    match_flat;
    result_t res_data;
    result_t out_data;
    logic    take;

    assign take = requests.valid && requests.ready;

    // Unpack the request bitmap
    for (genvar i = 0; i < PORTS; i++)
    begin : g_req_row
        for (genvar j = 0; j < PORTS; j++)
        begin : g_req_col
            if (i * PORTS + j < MAP_W)
            begin : g_in
                assign col_req[j][i] = requests.voq_nonempty[i * PORTS + j];
            end
            else
            begin : g_out
                assign col_req[j][i] = 1'b0;
            end
            assign row_gnt[i][j] = col_gnt[j][i];
        end
    end

    // Grant lanes, one per output
    for (genvar j = 0; j < PORTS; j++)
    begin : g_grant
        isl_rr_arb #(.N(PORTS)) u_grant (
            .req (col_req[j]),
            .ptr (gptr_reg[j]),
            .gnt (col_gnt[j]),
            .idx (gidx[j]),
            .any (gany[j])
        );
    end

    // Accept lanes, one per input
    for (genvar i = 0; i < PORTS; i++)
    begin : g_accept
        isl_rr_arb #(.N(PORTS)) u_accept (
            .req (row_gnt[i]),
            .ptr (aptr_reg[i]),
            .gnt (row_acc[i]),
            .idx (aidx[i]),
            .any (aany[i])
        );
    end

    // Merge: was each output's grant accepted by the input it chose
    always_comb
    begin
        for (int j = 0; j < PORTS; j++)
        begin
            col_accepted[j] = gany[j] && row_acc[gidx[j]][j];
        end
    end

    // Pointer update: one past the accepted output / accepting input
    always_comb
    begin
        for (int k = 0; k < PORTS; k++)
        begin
            gptr_next[k] = gptr_reg[k];
            aptr_next[k] = aptr_reg[k];
            if (col_accepted[k])
            begin
                gptr_next[k] = (gidx[k] == PW'(PORTS - 1)) ? '0 : gidx[k] + PW'(1);
            end
            if (aany[k])
            begin
                aptr_next[k] = (aidx[k] == PW'(PORTS - 1)) ? '0 : aidx[k] + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gptr_reg <= '0;
            aptr_reg <= '0;
        end
        else if (take)
        begin
            gptr_reg <= gptr_next;
            aptr_reg <= aptr_next;
        end
    end

    // Flatten into the port bit layout
    for (genvar k = 0; k < MAP_W; k++)
    begin : g_flat
        if (k < PORTS * PORTS)
        begin : g_used
            assign req_flat[k]   = col_req[k % PORTS][k / PORTS];
            assign grant_flat[k] = col_gnt[k % PORTS][k / PORTS];
            assign match_flat[k] = row_acc[k / PORTS][k % PORTS];
        end
        else
        begin : g_unused
            assign req_flat[k]   = 1'b0;
            assign grant_flat[k] = 1'b0;
            assign match_flat[k] = 1'b0;
        end
    end

    assign res_data.match_map = match_flat;
    assign res_data.grant_map = grant_flat;

    // Output register and skid
    isl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (requests.valid),
        .in_ready  (requests.ready),
        .in_data   (res_data),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (out_data)
    );

    assign results.match_map = out_data.match_map;
    assign results.grant_map = out_data.grant_map;

    // Every match rests on a grant
    a_match_in_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (match_flat & ~grant_flat) == '0)
        else $error("match without grant");

    // Every grant rests on a request
    a_grant_in_req: assert property (@(posedge clk) disable iff (!rst_n)
        (grant_flat & ~req_flat) == '0)
        else $error("grant without request");

    // Input 0, when it accepts, takes its new pointer on the next edge
    a_aptr_move: assert property (@(posedge clk) disable iff (!rst_n)
        (take && aany[0]) |=> (aptr_reg[0] == $past(aptr_next[0])))
        else $error("accept pointer of input 0 not updated");

endmodule
